/* design/lpvs_pkg.sv */
// Shared types, constants and helpers for the Logan/Patlak voxel slope engine.
package lpvs_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int FRAC_BITS  = 16;
    localparam int FIW        = $clog2(MAX_FRAMES + 1);
    localparam int DIV_W      = 128;

    localparam logic [2:0] CFG_MODE     = 3'd0;
    localparam logic [2:0] CFG_ARTERIAL = 3'd1;
    localparam logic [2:0] CFG_K2       = 3'd2;
    localparam logic [2:0] CFG_START    = 3'd3;
    localparam logic [2:0] CFG_BP       = 3'd4;
    localparam logic [2:0] CFG_CMRG     = 3'd5;
    localparam logic [2:0] CFG_PG       = 3'd6;
    localparam logic [2:0] CFG_LC       = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_ZDEN  = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef struct packed {
        logic signed [31:0] voxel_sample;
        logic signed [31:0] ref_sample;
        logic        [31:0] frame_duration;
        logic               in_region;
        logic               last_frame;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] slope;
        logic        [1:0]  status;
    } out_word_t;

    typedef struct packed {
        logic        mode;
        logic        arterial;
        logic [31:0] k2;
        logic [5:0]  start;
        logic        bp;
        logic        cmrg;
        logic [31:0] pg;
        logic [31:0] lc;
    } cfg_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_INTEG, OP_DIV_K2, OP_DIV_Y, OP_DIV_X, OP_ACCUM,
        OP_FIT_A, OP_FIT_B, OP_DIV_SLOPE, OP_ADJ, OP_DIV_CMRG, OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t  op;
        logic start_div;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic active;
        logic want_k2;
        logic last;
        logic few;
        logic zden;
        logic want_cmrg;
        logic fit_last;
    } stat_t;

    // Signed saturation of a 128-bit value to w bits, returned sign-extended.
    function automatic logic signed [127:0] sat_to(input logic signed [127:0] v,
                                                   input int w, output logic hit);
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        begin
            hi_lim = (128'sd1 <<< (w - 1)) - 128'sd1;
            lo_lim = -(128'sd1 <<< (w - 1));
            hit = 1'b0;
            sat_to = v;
            if (v > hi_lim) begin
                sat_to = hi_lim;
                hit = 1'b1;
            end else if (v < lo_lim) begin
                sat_to = lo_lim;
                hit = 1'b1;
            end
        end
    endfunction

endpackage

/* design/logan_patlak_voxel_slope_top.sv */
// Top level: configuration registers, controller and datapath.
// A non-final frame is loaded and integrated; inside a fit window it also runs up to
// three divisions (k2 term, y, x) in the shared divider. A final frame adds the fit
// and up to two more divisions (slope, CMRG). One frame word is processed at a time;
// a waiting result word sits in the output register.
// Reset: aresetn, synchronous active low.
module logan_patlak_voxel_slope_top
    import lpvs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    cfg_t      cfg_reg;
    cmd_t      cmd;
    stat_t     stat;
    out_word_t res;
    out_word_t out_reg;
    logic      res_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{mode: 1'b0, arterial: 1'b0, k2: 32'h10000, start: 6'd0,
                         bp: 1'b0, cmrg: 1'b0, pg: 32'h10000, lc: 32'h10000};
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MODE:     cfg_reg.mode     <= cfg_data[0];
                CFG_ARTERIAL: cfg_reg.arterial <= cfg_data[0];
                CFG_K2:       cfg_reg.k2       <= cfg_data;
                CFG_START:    cfg_reg.start    <= cfg_data[5:0];
                CFG_BP:       cfg_reg.bp       <= cfg_data[0];
                CFG_CMRG:     cfg_reg.cmrg     <= cfg_data[0];
                CFG_PG:       cfg_reg.pg       <= cfg_data;
                default:      cfg_reg.lc       <= cfg_data;
            endcase
        end
    end

    lpvs_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .bp(cfg_reg.bp), .mode(cfg_reg.mode),
        .stat(stat), .cmd(cmd), .res_load(res_load)
    );

    lpvs_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .cmd(cmd),
        .in_word(s_data), .stat(stat), .result(res)
    );

    // The result word is captured as the controller leaves its output state.
    always_ff @(posedge aclk) begin
        if (res_load) out_reg <= res;
    end
    assign m_data = out_reg;

endmodule

/* design/lpvs_div.sv */
// Iterative signed divider, one quotient bit a cycle, truncating toward zero.
module lpvs_div
    import lpvs_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [DIV_W-1:0] num,
    input  logic signed [DIV_W-1:0] den,
    output logic                    done,
    output logic signed [DIV_W-1:0] quo
);
    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] n_reg, q_reg, d_reg, r_reg;
    logic             neg_reg, busy_reg, done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W-1:0] rsh;

    assign rsh   = {r_reg[DIV_W-2:0], n_reg[DIV_W-1]};
    assign trial = {1'b0, rsh} - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_W);
                n_reg    <= num[DIV_W-1] ? DIV_W'(-num) : num;
                d_reg    <= den[DIV_W-1] ? DIV_W'(-den) : den;
                neg_reg  <= num[DIV_W-1] ^ den[DIV_W-1];
                r_reg    <= '0;
                q_reg    <= '0;
            end else if (busy_reg) begin
                n_reg <= {n_reg[DIV_W-2:0], 1'b0};
                if (d_reg != '0 && !trial[DIV_W]) begin
                    r_reg <= trial[DIV_W-1:0];
                    q_reg <= {q_reg[DIV_W-2:0], 1'b1};
                end else begin
                    r_reg <= rsh;
                    q_reg <= {q_reg[DIV_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = (neg_reg && d_reg != '0) ? -$signed(q_reg) : $signed(q_reg);

endmodule

/* design/lpvs_datapath.sv */
// Integrals, plot points, regression sums and slope arithmetic.
module lpvs_datapath
    import lpvs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  cmd_t      cmd,
    input  in_word_t  in_word,
    output stat_t     stat,
    output out_word_t result
);
    in_word_t                 cur_reg;
    logic [FIW-1:0]           frame_reg, count_reg;
    logic signed [47:0]       vint_reg, rint_reg, sx_reg, sy_reg;
    logic signed [31:0]       pv_reg, pr_reg, x_reg, y_reg, slope_reg;
    logic signed [63:0]       sxx_reg, sxy_reg, k2t_reg;
    logic signed [127:0]      num_reg, den_reg;
    logic                     sat_reg, active_reg;
    logic [1:0]               fa_reg;
    logic signed [DIV_W-1:0]  dnum, dden, dquo;
    logic                     dstart, ddone;

    lpvs_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart),
        .num(dnum), .den(dden), .done(ddone), .quo(dquo)
    );

    assign dstart = cmd.start_div;

    logic signed [32:0] k2s, lcs;
    assign k2s = (cfg.k2 == '0) ? 33'sd1 : $signed({1'b0, cfg.k2});
    assign lcs = (cfg.lc == '0) ? 33'sd1 : $signed({1'b0, cfg.lc});

    always_comb begin
        dnum = '0;
        dden = '0;
        case (cmd.op)
            OP_DIV_K2: begin
                dnum = 128'(cur_reg.ref_sample) <<< FRAC_BITS;
                dden = 128'(k2s);
            end
            OP_DIV_Y: begin
                if (!cfg.mode) begin
                    dnum = 128'(vint_reg) <<< FRAC_BITS;
                    dden = 128'(cur_reg.voxel_sample);
                end else begin
                    dnum = 128'(cur_reg.voxel_sample) <<< FRAC_BITS;
                    dden = 128'(cur_reg.ref_sample);
                end
            end
            OP_DIV_X: begin
                if (!cfg.mode) begin
                    dnum = (128'(rint_reg) + (cfg.arterial ? 128'sd0 : 128'(k2t_reg)))
                           <<< FRAC_BITS;
                    dden = 128'(cur_reg.voxel_sample);
                end else begin
                    dnum = 128'(rint_reg) <<< FRAC_BITS;
                    dden = 128'(cur_reg.ref_sample);
                end
            end
            OP_DIV_SLOPE: begin
                dnum = num_reg <<< FRAC_BITS;
                dden = den_reg;
            end
            OP_DIV_CMRG: begin
                dnum = 128'(slope_reg) * 128'($signed({1'b0, cfg.pg}));
                dden = 128'(lcs);
            end
            default: ;
        endcase
    end

    // Trapezoid step and saturation helpers.
    logic signed [127:0] vi_n, ri_n, q_sat, t_sat;
    logic                h0, h1, h2, h3;
    always_comb begin
        vi_n = sat_to(128'(vint_reg) + ((128'($signed({1'b0, cur_reg.frame_duration}))
               * (128'(pv_reg) + 128'(cur_reg.voxel_sample))) >>> (FRAC_BITS + 1)), 48, h0);
        ri_n = sat_to(128'(rint_reg) + ((128'($signed({1'b0, cur_reg.frame_duration}))
               * (128'(pr_reg) + 128'(cur_reg.ref_sample))) >>> (FRAC_BITS + 1)), 48, h1);
        q_sat = sat_to(dquo, 32, h2);
        t_sat = sat_to(dquo, 64, h3);
    end

    logic signed [127:0] sx_n, sy_n, sxx_n, sxy_n, adj_n;
    logic                h4, h5, h6, h7, h8;
    always_comb begin
        sx_n  = sat_to(128'(sx_reg) + 128'(x_reg), 48, h4);
        sy_n  = sat_to(128'(sy_reg) + 128'(y_reg), 48, h5);
        sxx_n = sat_to(128'(sxx_reg) + ((128'(x_reg) * 128'(x_reg)) >>> FRAC_BITS), 64, h6);
        sxy_n = sat_to(128'(sxy_reg) + ((128'(x_reg) * 128'(y_reg)) >>> FRAC_BITS), 64, h7);
        adj_n = sat_to(128'(slope_reg) - (128'sd1 <<< FRAC_BITS), 32, h8);
    end

    // Sx*Sy and Sx*Sx are built from the three 16-bit slices of the second factor,
    // one slice a cycle; only the top slice carries the sign.
    logic signed [16:0] ly, lx;
    logic signed [64:0] pxy, pxx;
    logic [5:0]         fa_sh;
    always_comb begin
        case (fa_reg)
            2'd0: begin
                ly = $signed({1'b0, sy_reg[15:0]});
                lx = $signed({1'b0, sx_reg[15:0]});
            end
            2'd1: begin
                ly = $signed({1'b0, sy_reg[31:16]});
                lx = $signed({1'b0, sx_reg[31:16]});
            end
            default: begin
                ly = $signed({sy_reg[47], sy_reg[47:32]});
                lx = $signed({sx_reg[47], sx_reg[47:32]});
            end
        endcase
        pxy   = 65'(sx_reg) * 65'(ly);
        pxx   = 65'(sx_reg) * 65'(lx);
        fa_sh = {fa_reg, 4'b0000};
    end

    logic point_zero;
    assign point_zero = (cur_reg.voxel_sample == 0) || (cfg.mode && cur_reg.ref_sample == 0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= '0; count_reg <= '0;
            vint_reg <= '0; rint_reg <= '0; pv_reg <= '0; pr_reg <= '0;
            sx_reg <= '0; sy_reg <= '0; sxx_reg <= '0; sxy_reg <= '0;
            active_reg <= 1'b0;
            fa_reg <= '0;
        end else begin
            case (cmd.op)
                OP_LOAD: begin
                    cur_reg    <= in_word;
                    active_reg <= (frame_reg < FIW'(MAX_FRAMES));
                    x_reg <= '0; y_reg <= '0; k2t_reg <= '0;
                    sat_reg <= 1'b0;
                end
                OP_INTEG: if (active_reg) begin
                    vint_reg <= vi_n[47:0];
                    rint_reg <= ri_n[47:0];
                    pv_reg   <= cur_reg.voxel_sample;
                    pr_reg   <= cur_reg.ref_sample;
                    frame_reg <= frame_reg + FIW'(1);
                    active_reg <= (frame_reg >= FIW'(cfg.start));
                end
                OP_DIV_K2:   if (ddone) k2t_reg <= t_sat[63:0];
                OP_DIV_Y:    if (ddone) y_reg <= point_zero ? 32'sd0 : q_sat[31:0];
                OP_DIV_X:    if (ddone) x_reg <= point_zero ? 32'sd0 : q_sat[31:0];
                OP_ACCUM: begin
                    sx_reg <= sx_n[47:0]; sy_reg <= sy_n[47:0];
                    sxx_reg <= sxx_n[63:0]; sxy_reg <= sxy_n[63:0];
                    count_reg <= count_reg + FIW'(1);
                end
                OP_FIT_A: begin
                    num_reg <= ((fa_reg == 2'd0) ? 128'sd0 : num_reg) + (128'(pxy) <<< fa_sh);
                    den_reg <= ((fa_reg == 2'd0) ? 128'sd0 : den_reg) + (128'(pxx) <<< fa_sh);
                    fa_reg  <= (fa_reg == 2'd2) ? 2'd0 : fa_reg + 2'd1;
                end
                OP_FIT_B: begin
                    num_reg <= 128'($signed({1'b0, count_reg})) * 128'(sxy_reg)
                               - (num_reg >>> FRAC_BITS);
                    den_reg <= 128'($signed({1'b0, count_reg})) * 128'(sxx_reg)
                               - (den_reg >>> FRAC_BITS);
                end
                OP_DIV_SLOPE: if (ddone) begin
                    slope_reg <= q_sat[31:0];
                    sat_reg   <= h2;
                end
                OP_ADJ: begin
                    slope_reg <= adj_n[31:0];
                    sat_reg   <= sat_reg | h8;
                end
                OP_DIV_CMRG: if (ddone) begin
                    slope_reg <= q_sat[31:0];
                    sat_reg   <= sat_reg | h2;
                end
                OP_CLEAR: begin
                    frame_reg <= '0; count_reg <= '0;
                    vint_reg <= '0; rint_reg <= '0; pv_reg <= '0; pr_reg <= '0;
                    sx_reg <= '0; sy_reg <= '0; sxx_reg <= '0; sxy_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    assign stat.div_done  = ddone;
    assign stat.active    = active_reg;
    assign stat.want_k2   = !cfg.mode && !cfg.arterial;
    assign stat.last      = cur_reg.last_frame;
    assign stat.few       = !cur_reg.in_region || count_reg <= FIW'(3);
    assign stat.zden      = (den_reg == '0);
    assign stat.want_cmrg = cfg.mode && cfg.cmrg;
    assign stat.fit_last  = (fa_reg == 2'd2);

    always_comb begin
        if (!cur_reg.in_region) begin
            result.slope = '0; result.status = ST_OK;
        end else if (count_reg <= FIW'(3)) begin
            result.slope = '0; result.status = ST_FEW;
        end else if (den_reg == '0) begin
            result.slope = '0; result.status = ST_ZDEN;
        end else begin
            result.slope = slope_reg; result.status = sat_reg ? ST_SAT : ST_OK;
        end
    end

endmodule

/* design/lpvs_ctrl.sv */
// Sequencer that steps the datapath through one frame word.
module lpvs_ctrl
    import lpvs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  logic  bp,
    input  logic  mode,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  res_load
);
    typedef enum logic [3:0] {
        S_IDLE, S_INTEG, S_CHK, S_K2, S_Y, S_X, S_ACC, S_END,
        S_FA, S_FB, S_SL, S_ADJ, S_CM, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;
    logic   mv_reg, mv_next;

    always_comb begin
        state_next  = state_reg;
        issued_next = issued_reg;
        mv_next     = mv_reg;
        cmd.op        = OP_NONE;
        cmd.start_div = 1'b0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            S_IDLE: if (s_valid) begin
                cmd.op = OP_LOAD;
                state_next = S_INTEG;
            end
            S_INTEG: begin
                cmd.op = OP_INTEG;
                state_next = stat.active ? S_CHK : S_END;
            end
            S_CHK: state_next = stat.active ? (stat.want_k2 ? S_K2 : S_Y) : S_END;
            S_K2, S_Y, S_X, S_SL, S_CM: begin
                unique case (state_reg)
                    S_K2:    cmd.op = OP_DIV_K2;
                    S_Y:     cmd.op = OP_DIV_Y;
                    S_X:     cmd.op = OP_DIV_X;
                    S_SL:    cmd.op = OP_DIV_SLOPE;
                    default: cmd.op = OP_DIV_CMRG;
                endcase
                if (!issued_reg) begin
                    cmd.start_div = 1'b1;
                    issued_next = 1'b1;
                end else if (stat.div_done) begin
                    issued_next = 1'b0;
                    unique case (state_reg)
                        S_K2:    state_next = S_Y;
                        S_Y:     state_next = S_X;
                        S_X:     state_next = S_ACC;
                        S_SL:    state_next = (!mode && bp) ? S_ADJ
                                            : (stat.want_cmrg ? S_CM : S_OUT);
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_ACC: begin
                cmd.op = OP_ACCUM;
                state_next = S_END;
            end
            S_END: state_next = !stat.last ? S_IDLE : (stat.few ? S_OUT : S_FA);
            S_FA: begin
                cmd.op = OP_FIT_A;
                if (stat.fit_last) state_next = S_FB;
            end
            S_FB: begin
                cmd.op = OP_FIT_B;
                state_next = S_SL;
            end
            S_ADJ: begin
                cmd.op = OP_ADJ;
                state_next = S_OUT;
            end
            S_OUT: begin
                // The finished word waits here while the previous one is still held.
                if (!mv_reg || m_ready) begin
                    cmd.op = OP_CLEAR;
                    if (stat.zden && !stat.few) issued_next = 1'b0;
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // A zero denominator skips the slope division.
        if (state_reg == S_FB) state_next = S_SL;
    end

    logic zskip;
    assign zskip = (state_reg == S_SL) && stat.zden && !issued_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= zskip ? S_OUT : state_next;
            issued_reg <= zskip ? 1'b0 : issued_next;
            mv_reg     <= mv_next;
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = mv_reg;
    assign res_load = (state_reg == S_OUT) && (!mv_reg || m_ready);

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && m_valid && !m_ready) |=> (state_reg == S_OUT))
        else $error("finished word overwrote a waiting result word");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_div |=> !cmd.start_div)
        else $error("divider restarted on consecutive cycles");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result word dropped before it was taken");

endmodule
